@@ src/uer_pkg.sv @@
package uer_pkg;

  // Measurement phase of the ranger.
  localparam logic [1:0] PhIdle = 2'd0;
  localparam logic [1:0] PhTrig = 2'd1;
  localparam logic [1:0] PhRise = 2'd2;
  localparam logic [1:0] PhHigh = 2'd3;

  // Outcome codes reported with done.
  localparam logic [1:0] OutValid   = 2'd0;
  localparam logic [1:0] OutNoRise  = 2'd1;
  localparam logic [1:0] OutTooLong = 2'd2;
  localparam logic [1:0] OutRange   = 2'd3;

  // Configuration register indexes.
  localparam logic [2:0] RegTrigTicks   = 3'd0;
  localparam logic [2:0] RegTimeout     = 3'd1;
  localparam logic [2:0] RegDistFactor  = 3'd2;
  localparam logic [2:0] RegMinDist     = 3'd3;
  localparam logic [2:0] RegMaxDist     = 3'd4;
  localparam logic [2:0] RegDefaultDist = 3'd5;

  // Register reset values.
  localparam logic [7:0]  TrigTicksRst   = 8'd10;
  localparam logic [15:0] TimeoutRst     = 16'd3000;
  localparam logic [7:0]  DistFactorRst  = 8'd58;
  localparam logic [15:0] MinDistRst     = 16'd2;
  localparam logic [15:0] MaxDistRst     = 16'd400;
  localparam logic [15:0] DefaultDistRst = 16'd0;

  // Pulse counter and quotient width, and distance factor width.
  localparam int unsigned PulseW = 17;
  localparam int unsigned FactW  = 8;

  // Divider status seen by the sequencer.
  typedef struct packed {
    logic                busy;
    logic [PulseW-1:0]   quotient;
  } div_stat_t;

endpackage

@@ src/ultrasonic_echo_ranger_core.sv @@
// Ultrasonic echo ranger core.
// Each word on the slave stream is one microsecond tick carrying a start
// request and the sampled echo level. For every accepted word exactly one
// word leaves on the master stream, giving the trigger drive level, the held
// distance, busy, done and an outcome code, all after that tick's update.
// Configuration registers are written through the cfg channel, which is
// always ready; write them only while no measurement is running.
// Most words have their result computed at acceptance, and it lands in the
// output register in the cycle after. The tick that ends an echo pulse
// starts the restoring divider, which produces one quotient bit per cycle;
// that word's result reaches the output register once the divider is done
// and the output register is free. No new word is taken meanwhile.
// The next word is accepted while a finished result waits, provided the
// output register is empty or drained in that same cycle.
// Reset clears all control state, loads the register reset values and sets
// the held distance to the default distance reset value. When the receiver
// stalls, the output word holds and input acceptance stops once a second
// result would need the output register.
module ultrasonic_echo_ranger_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream, tdata bit 0 start_request, bit 1 echo_level, rest zero.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,
  // Output stream, tdata bit 0 trigger_level, bits 16:1 held_distance,
  // bit 17 busy_res, bit 18 done_res, bits 20:19 outcome, rest zero.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,
  // Configuration write channel.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import uer_pkg::*;

  // Sequencer states: taking ticks, or waiting on the divider.
  localparam logic StIn  = 1'b0;
  localparam logic StDiv = 1'b1;

  logic st_q, st_d;

  // Configuration registers.
  logic [7:0]  trig_ticks_q;
  logic [15:0] timeout_q;
  logic [7:0]  dist_factor_q;
  logic [15:0] min_dist_q;
  logic [15:0] max_dist_q;

  // Measurement state.
  logic [1:0]        phase_q, phase_d;
  logic [15:0]       tick_q, tick_d;
  logic [PulseW-1:0] pulse_q, pulse_d;
  logic [15:0]       good_q, good_d;

  // Output register.
  logic        ovalid_q, ovalid_d;
  logic        o_trig_q, o_trig_d;
  logic        o_busy_q, o_busy_d;
  logic        o_done_q, o_done_d;
  logic [1:0]  o_code_q, o_code_d;

  logic        in_acc;
  logic        out_free;
  logic        start_req;
  logic        echo;
  logic [7:0]  trig_len;
  logic [15:0] tick_inc;
  logic [PulseW-1:0] pulse_inc;
  logic        trig;
  logic        done;
  logic [1:0]  code;
  logic        need_div;
  logic        div_start;
  logic [FactW-1:0] divisor;
  div_stat_t   div_stat;
  logic        in_range;

  assign cfg_ready_o = 1'b1;

  // The output register can take a new word when empty or being drained now.
  assign out_free      = !ovalid_q || m_axis_tready;
  assign s_axis_tready = (st_q == StIn) && out_free;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  assign start_req = s_axis_tdata[0];
  assign echo      = s_axis_tdata[1];
  assign trig_len  = (trig_ticks_q == 8'd0) ? 8'd1 : trig_ticks_q;
  assign divisor   = (dist_factor_q == '0) ? FactW'(1) : dist_factor_q;
  assign tick_inc  = tick_q + 16'd1;
  assign pulse_inc = pulse_q + PulseW'(1);

  // One tick of the measurement sequence.
  always_comb begin
    phase_d  = phase_q;
    tick_d   = tick_q;
    pulse_d  = pulse_q;
    trig     = 1'b0;
    done     = 1'b0;
    code     = OutValid;
    need_div = 1'b0;
    case (phase_q)
      PhIdle: begin
        if (start_req) begin
          trig = 1'b1;
          if (trig_len == 8'd1) begin
            phase_d = PhRise;
            tick_d  = '0;
          end else begin
            phase_d = PhTrig;
            tick_d  = 16'd1;
          end
        end
      end
      PhTrig: begin
        trig = 1'b1;
        if (tick_inc >= {8'd0, trig_len}) begin
          phase_d = PhRise;
          tick_d  = '0;
        end else begin
          tick_d = tick_inc;
        end
      end
      PhRise: begin
        if (echo) begin
          pulse_d = PulseW'(1);
          if (timeout_q == 16'd0) begin
            done    = 1'b1;
            code    = OutTooLong;
            phase_d = PhIdle;
          end else begin
            phase_d = PhHigh;
          end
        end else if (tick_q >= timeout_q) begin
          done    = 1'b1;
          code    = OutNoRise;
          phase_d = PhIdle;
        end else begin
          tick_d = tick_inc;
        end
      end
      PhHigh: begin
        if (echo) begin
          pulse_d = pulse_inc;
          if (pulse_inc > {1'b0, timeout_q}) begin
            done    = 1'b1;
            code    = OutTooLong;
            phase_d = PhIdle;
          end
        end else begin
          // Pulse ended: the distance comes from the divider.
          need_div = 1'b1;
          done     = 1'b1;
          phase_d  = PhIdle;
        end
      end
      default: begin
        phase_d = PhIdle;
      end
    endcase
  end

  assign div_start = in_acc && need_div;

  uer_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (pulse_q),
    .divisor_i  (divisor),
    .stat_o     (div_stat)
  );

  assign in_range = (div_stat.quotient >= {1'b0, min_dist_q}) &&
                    (div_stat.quotient <= {1'b0, max_dist_q});

  // Sequencer and output register update.
  always_comb begin
    st_d     = st_q;
    good_d   = good_q;
    ovalid_d = ovalid_q && !m_axis_tready;
    o_trig_d = o_trig_q;
    o_busy_d = o_busy_q;
    o_done_d = o_done_q;
    o_code_d = o_code_q;
    case (st_q)
      StIn: begin
        if (in_acc) begin
          if (need_div) begin
            st_d = StDiv;
          end else begin
            ovalid_d = 1'b1;
            o_trig_d = trig;
            o_busy_d = (phase_d != PhIdle);
            o_done_d = done;
            o_code_d = code;
          end
        end
      end
      StDiv: begin
        if (!div_stat.busy && out_free) begin
          st_d     = StIn;
          ovalid_d = 1'b1;
          o_trig_d = 1'b0;
          o_busy_d = 1'b0;
          o_done_d = 1'b1;
          if (in_range) begin
            good_d   = div_stat.quotient[15:0];
            o_code_d = OutValid;
          end else begin
            o_code_d = OutRange;
          end
        end
      end
      default: begin
        st_d = StIn;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q          <= StIn;
      phase_q       <= PhIdle;
      tick_q        <= '0;
      pulse_q       <= '0;
      good_q        <= DefaultDistRst;
      ovalid_q      <= 1'b0;
      trig_ticks_q  <= TrigTicksRst;
      timeout_q     <= TimeoutRst;
      dist_factor_q <= DistFactorRst;
      min_dist_q    <= MinDistRst;
      max_dist_q    <= MaxDistRst;
    end else begin
      st_q     <= st_d;
      good_q   <= good_d;
      ovalid_q <= ovalid_d;
      if (in_acc) begin
        phase_q <= phase_d;
        tick_q  <= tick_d;
        pulse_q <= pulse_d;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        // The default distance only matters at reset, so a later write to
        // its index has no effect and is dropped like any unknown index.
        case (cfg_index_i)
          RegTrigTicks:  trig_ticks_q  <= cfg_data_i[7:0];
          RegTimeout:    timeout_q     <= cfg_data_i;
          RegDistFactor: dist_factor_q <= cfg_data_i[7:0];
          RegMinDist:    min_dist_q    <= cfg_data_i;
          RegMaxDist:    max_dist_q    <= cfg_data_i;
          RegDefaultDist: ;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    o_trig_q <= o_trig_d;
    o_busy_q <= o_busy_d;
    o_done_q <= o_done_d;
    o_code_q <= o_code_d;
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {3'b000, o_code_q, o_done_q, o_busy_q, good_q, o_trig_q};

  // The divider is never restarted while it is still working.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_stat.busy)
    else $error("divider restarted while busy");

  // No input is taken while a division is outstanding.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == StDiv) |-> !s_axis_tready)
    else $error("input accepted during division");

  // A nonzero outcome is only ever reported together with done.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (o_done_q || (o_code_q == OutValid)))
    else $error("outcome without done");

  // A division start leads the sequencer into the divide wait.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |=> (st_q == StDiv) && div_stat.busy)
    else $error("division not tracked");

endmodule

@@ src/uer_div.sv @@
module uer_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [uer_pkg::PulseW-1:0] dividend_i,
  input  logic [uer_pkg::FactW-1:0]  divisor_i,
  output uer_pkg::div_stat_t        stat_o
);
  import uer_pkg::*;

  // Restoring divider, one quotient bit per cycle, MSB first.
  localparam int unsigned CntW = $clog2(PulseW + 1);
  localparam logic [CntW-1:0] Steps = CntW'(PulseW);

  logic [PulseW-1:0] quo_q, quo_d;
  logic [FactW-1:0]  rem_q, rem_d;
  logic [FactW-1:0]  dvs_q, dvs_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              busy_q, busy_d;

  logic [FactW:0]    rem_sh;
  logic [FactW+1:0]  trial;

  always_comb begin
    rem_sh = {rem_q, quo_q[PulseW-1]};
    trial  = {1'b0, rem_sh} - {2'b00, dvs_q};
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
      cnt_d  = Steps;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial[FactW+1]) begin
        rem_d = rem_sh[FactW-1:0];
        quo_d = {quo_q[PulseW-2:0], 1'b0};
      end else begin
        rem_d = trial[FactW-1:0];
        quo_d = {quo_q[PulseW-2:0], 1'b1};
      end
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign stat_o.busy     = busy_q;
  assign stat_o.quotient = quo_q;

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
  import uer_pkg::*;

  // The run is stopped here even if the block hangs.
  localparam int unsigned CycleLimit = 400000;

  typedef struct packed {
    logic        trig;
    logic [15:0] held;
    logic        busy;
    logic        done;
    logic [1:0]  outcome;
  } tick_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // Bit 0 start_request, bit 1 echo_level, bits 7:2 zero.
  logic [7:0]  s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // Bit 0 trigger_level, bits 16:1 held_distance, bit 17 busy_res,
  // bit 18 done_res, bits 20:19 outcome, bits 23:21 zero.
  logic [23:0] m_axis_tdata;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;

  // Words waiting for the driver, and the results they must produce.
  logic [7:0]  tick_words[$];
  tick_res_t   expected_ticks[$];
  int unsigned fail_cnt = 0;
  int unsigned cycle_cnt = 0;
  // While set, neither side inserts idle cycles.
  logic        quiet = 1'b0;

  // Ranger state and register copies, as the block holds them.
  logic [1:0]  ph = PhIdle;
  logic [15:0] tick_cnt = '0;
  logic [16:0] pulse_cnt = '0;
  logic [15:0] held_cm = DefaultDistRst;
  logic [7:0]  cfg_trig = TrigTicksRst;
  logic [15:0] cfg_timeout = TimeoutRst;
  logic [7:0]  cfg_factor = DistFactorRst;
  logic [15:0] cfg_min = MinDistRst;
  logic [15:0] cfg_max = MaxDistRst;
  logic [15:0] cfg_default = DefaultDistRst;

  ultrasonic_echo_ranger_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Advances the ranger by one microsecond tick and returns what it reports.
  task automatic ranger_tick(input logic start, input logic echo, output tick_res_t r);
    logic [7:0]  trig_len;
    logic [7:0]  divisor;
    logic [16:0] dist_cm;
    r = '0;
    trig_len = (cfg_trig == 8'd0) ? 8'd1 : cfg_trig;
    case (ph)
      PhIdle: begin
        if (start) begin
          r.trig = 1'b1;
          tick_cnt = 16'd1;
          ph = PhTrig;
          if (tick_cnt >= trig_len) begin
            ph = PhRise;
            tick_cnt = '0;
          end
        end
      end
      PhTrig: begin
        r.trig = 1'b1;
        tick_cnt = tick_cnt + 16'd1;
        if (tick_cnt >= trig_len) begin
          ph = PhRise;
          tick_cnt = '0;
        end
      end
      PhRise: begin
        if (echo) begin
          // The tick that sees the rise is already the first pulse tick.
          pulse_cnt = 17'd1;
          ph = PhHigh;
          if (pulse_cnt > cfg_timeout) begin
            r.done = 1'b1;
            r.outcome = OutTooLong;
            ph = PhIdle;
          end
        end else if (tick_cnt >= cfg_timeout) begin
          r.done = 1'b1;
          r.outcome = OutNoRise;
          ph = PhIdle;
        end else begin
          tick_cnt = tick_cnt + 16'd1;
        end
      end
      PhHigh: begin
        if (echo) begin
          pulse_cnt = pulse_cnt + 17'd1;
          if (pulse_cnt > cfg_timeout) begin
            r.done = 1'b1;
            r.outcome = OutTooLong;
            ph = PhIdle;
          end
        end else begin
          divisor = (cfg_factor == 8'd0) ? 8'd1 : cfg_factor;
          dist_cm = pulse_cnt / divisor;
          // An inverted range can never hold a reading.
          if (dist_cm >= cfg_min && dist_cm <= cfg_max) begin
            held_cm = dist_cm[15:0];
            r.outcome = OutValid;
          end else begin
            r.outcome = OutRange;
          end
          r.done = 1'b1;
          ph = PhIdle;
        end
      end
      default: ph = PhIdle;
    endcase
    r.held = held_cm;
    r.busy = (ph != PhIdle);
  endtask

  task automatic send_tick(input logic start, input logic echo);
    tick_res_t r;
    ranger_tick(start, echo, r);
    expected_ticks.push_back(r);
    tick_words.push_back({6'b0, echo, start});
  endtask

  // Only called while no measurement runs and no word is in flight.
  task automatic program_reg(input logic [2:0] idx, input logic [15:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      RegTrigTicks:   cfg_trig = val[7:0];
      RegTimeout:     cfg_timeout = val;
      RegDistFactor:  cfg_factor = val[7:0];
      RegMinDist:     cfg_min = val;
      RegMaxDist:     cfg_max = val;
      RegDefaultDist: cfg_default = val;
      default: ;
    endcase
  endtask

  task automatic program_all(input logic [7:0] trig, input logic [15:0] tmo,
                             input logic [7:0] fact, input logic [15:0] lo,
                             input logic [15:0] hi, input logic [15:0] dflt);
    program_reg(RegTrigTicks, {8'd0, trig});
    program_reg(RegTimeout, tmo);
    program_reg(RegDistFactor, {8'd0, fact});
    program_reg(RegMinDist, lo);
    program_reg(RegMaxDist, hi);
    program_reg(RegDefaultDist, dflt);
  endtask

  // Brings any running measurement to its end, then waits for every result.
  task automatic settle_ranger();
    while (ph != PhIdle) send_tick(1'b0, ph == PhRise);
    while (expected_ticks.size() != 0) @(negedge clk_i);
  endtask

  // Mostly well-formed measurements with random rise delays and pulse
  // lengths around the timeout, mixed with random noise words.
  task automatic random_ticks(input int unsigned n);
    int unsigned rise_len;
    int unsigned pulse_len;
    logic        st;
    logic        ec;
    rise_len = 0;
    pulse_len = 1;
    for (int unsigned i = 0; i < n; i++) begin
      st = 1'($urandom_range(1));
      ec = 1'($urandom_range(1));
      if ($urandom_range(99) >= 8) begin
        case (ph)
          PhIdle: begin
            st = ($urandom_range(99) < 60);
            if (st) begin
              rise_len = $urandom_range(cfg_timeout + 1);
              pulse_len = $urandom_range(cfg_timeout + 1, 1);
            end
          end
          PhRise: ec = (tick_cnt >= rise_len);
          PhHigh: ec = (pulse_cnt < pulse_len);
          default: ;
        endcase
      end
      send_tick(st, ec);
    end
  endtask

  // Input side: a word leaves the queue only once the previous one is taken.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (tick_words.size() != 0 && (quiet || $urandom_range(99) >= 13)) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= tick_words.pop_front();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  function automatic int unsigned field_bad(input string name, input int unsigned exp_v,
                                            input int unsigned act_v);
    if (exp_v == act_v) return 0;
    $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, act_v);
    return 1;
  endfunction

  task automatic check_tick(input logic [23:0] w);
    tick_res_t e;
    if (expected_ticks.size() == 0) begin
      $display("%0t: unexpected result word, expected none actual %h", $time, w);
      fail_cnt++;
      return;
    end
    e = expected_ticks.pop_front();
    fail_cnt += field_bad("trigger_level", 32'(e.trig), 32'(w[0]));
    fail_cnt += field_bad("held_distance", 32'(e.held), 32'(w[16:1]));
    fail_cnt += field_bad("busy", 32'(e.busy), 32'(w[17]));
    fail_cnt += field_bad("done", 32'(e.done), 32'(w[18]));
    fail_cnt += field_bad("outcome", 32'(e.outcome), 32'(w[20:19]));
  endtask

  // Output side: random back-pressure, every taken word checked in order.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= quiet || ($urandom_range(99) >= 13);
      if (m_axis_tvalid && m_axis_tready) check_tick(m_axis_tdata);
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset settings: a stray echo while idle, a start with requests and
    // echoes during the trigger, and a short pulse that lands below range.
    send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b0);
    repeat (9) send_tick(1'b1, 1'b1);
    repeat (3) send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b0);
    settle_ranger();

    // One-tick trigger, short timeout. The default distance write must
    // leave the held distance alone.
    program_all(8'd1, 16'd4, 8'd1, 16'd0, 16'hFFFF, 16'd1234);
    send_tick(1'b1, 1'b0);
    repeat (4) send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b0);                 // no rise; start on that tick ignored
    send_tick(1'b1, 1'b1);
    repeat (4) send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b1);                 // pulse too long
    send_tick(1'b1, 1'b0);
    repeat (2) send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b0);                 // good reading of 2
    settle_ranger();

    // Zero trigger length, zero timeout, zero divisor and an inverted range.
    program_all(8'd0, 16'd0, 8'd0, 16'hFFFF, 16'd0, 16'hFFFF);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b1);
    settle_ranger();
    program_reg(RegTimeout, 16'd3);
    send_tick(1'b1, 1'b0);
    repeat (2) send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b0);
    settle_ranger();
    program_reg(RegMinDist, 16'd3);
    program_reg(RegMaxDist, 16'd3);
    send_tick(1'b1, 1'b0);
    repeat (3) send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b0);
    settle_ranger();

    // Largest trigger, timeout and divisor: one long measurement.
    program_all(8'hFF, 16'hFFFF, 8'hFF, 16'd0, 16'hFFFF, 16'd0);
    send_tick(1'b1, 1'b0);
    repeat (254) send_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
    repeat (3) send_tick(1'b0, 1'b0);
    repeat (3) send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b0);
    settle_ranger();

    // Random settings per phase; one phase runs without any idle cycles.
    for (int unsigned p = 0; p < 4; p++) begin
      logic [15:0] lo;
      logic [15:0] hi;
      lo = 16'($urandom_range(4));
      hi = ($urandom_range(9) == 0 && lo != 0) ? lo - 16'd1 : 16'($urandom_range(30, lo));
      program_all(($urandom_range(4) == 0) ? 8'd0 : 8'($urandom_range(4, 1)),
                  16'($urandom_range(24, 2)), 8'($urandom_range(4)), lo, hi,
                  16'($urandom_range(16'hFFFF)));
      quiet = (p == 2);
      random_ticks(60);
      settle_ranger();
      quiet = 1'b0;
    end

    repeat (40) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
